@@ rtl/core/midi_clock_tick_generator_assert.svh @@
// assertion macros used by the checker of the midi clock tick generator
`ifndef MIDI_CLOCK_TICK_GENERATOR_ASSERT_SVH
`define MIDI_CLOCK_TICK_GENERATOR_ASSERT_SVH

// antecedent true at an edge implies consequent at the same edge
`define MCG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent true at an edge implies consequent at the following edge
`define MCG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mcg_pkg.sv @@
// shared constants and types of the midi clock tick generator
`default_nettype none

package mcg_pkg;

    typedef logic [7:0] status_t;

    // midi realtime status bytes
    localparam status_t ST_TICK  = 8'hF8;
    localparam status_t ST_START = 8'hFA;
    localparam status_t ST_STOP  = 8'hFC;

    // field widths
    localparam int START_W  = 48;
    localparam int LEN_W    = 11;
    localparam int TEMPO_W  = 19;
    localparam int RATE_W   = 19;
    localparam int OFFS_W   = 10;
    localparam int POS_W    = 49;
    localparam int QUO_W    = 32;
    localparam int CNT_W    = 5;

    // block length saturation and per-block event cap
    localparam int MAX_BLOCK  = 1024;
    localparam int RESULT_CAP = 17;

    // q = sample_rate * 5000 / tempo_milli_bpm, twice the tick interval
    localparam int TEMPO_SCALE = 5000;
    localparam int RATE_RESET  = 48000;
    localparam logic [QUO_W-1:0] DIVIDEND_RESET = QUO_W'(RATE_RESET * TEMPO_SCALE);

endpackage

`default_nettype wire

@@ rtl/core/mcg_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module mcg_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [mcg_pkg::QUO_W-1:0]    dividend,
    input  wire  [mcg_pkg::TEMPO_W-1:0]  divisor,
    output logic                         done,
    output logic [mcg_pkg::QUO_W-1:0]    quotient
);
    import mcg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [TEMPO_W-1:0]   rem_reg, rem_next;
    logic [TEMPO_W-1:0]   dsr_reg, dsr_next;
    logic [TEMPO_W:0]     rem_sh;
    logic [TEMPO_W:0]     rem_sub;
    logic                 ge;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[QUO_W-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        ge      = rem_sh >= {1'b0, dsr_reg};
    end

    // step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QUO_W-2:0], ge};
            rem_next = ge ? rem_sub[TEMPO_W-1:0] : rem_sh[TEMPO_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/mcg_core.sv @@
// block sequencer: transport edges, tick alignment, tick stepping and result staging
`default_nettype none

module mcg_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [mcg_pkg::QUO_W-1:0]    dividend,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [mcg_pkg::START_W-1:0]  s_block_start,
    input  wire  [mcg_pkg::LEN_W-1:0]    s_block_length,
    input  wire  [mcg_pkg::TEMPO_W-1:0]  s_tempo_milli_bpm,
    input  wire                          s_rolling,
    output logic                         div_start,
    input  wire                          div_done,
    input  wire  [mcg_pkg::QUO_W-1:0]    div_quotient,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [7:0]                   m_status_byte,
    output logic [mcg_pkg::OFFS_W-1:0]   m_sample_offset,
    output logic                         m_last
);
    import mcg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_ALIGN = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                was_rolling_reg, was_rolling_next;
    logic [POS_W-1:0]    ntp_reg, ntp_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]    end_reg, end_next;
    logic [QUO_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    status_t             pend_status_reg, pend_status_next;
    logic [OFFS_W-1:0]   pend_offset_reg, pend_offset_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [OFFS_W-1:0]   m_offset_reg, m_offset_next;
    logic                m_last_reg, m_last_next;

    logic                accept;
    logic                go;
    logic [LEN_W-1:0]    len_sat;
    logic                out_free;
    logic                push;
    logic                push_last;
    logic                in_blk;
    logic                emit;
    logic [QUO_W:0]      q_inc;
    logic [POS_W:0]      lag_sum;
    logic [OFFS_W-1:0]   tick_offset;

    // input side and derived terms
    always_comb begin
        accept      = s_valid && s_ready;
        len_sat     = (s_block_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                           : s_block_length;
        go          = accept && (s_block_length != '0) && (dividend != '0);
        out_free    = !m_valid_reg || m_ready;
        in_blk      = ntp_reg < end_reg;
        emit        = in_blk && (ntp_reg >= {1'b0, start_reg})
                      && (cnt_reg < CNT_W'(RESULT_CAP));
        q_inc       = {1'b0, div_quotient} + 1'b1;
        lag_sum     = {1'b0, ntp_reg} + (POS_W+1)'(div_quotient);
        // the offset is below the block length, so the low bits suffice
        tick_offset = ntp_reg[OFFS_W-1:0] - start_reg[OFFS_W-1:0];
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        was_rolling_next = was_rolling_reg;
        ntp_next         = ntp_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        step_next        = step_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_offset_next = pend_offset_reg;
        push             = 1'b0;
        push_last        = 1'b0;
        div_start        = 1'b0;
        s_ready          = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (go) begin
                    start_next = s_block_start;
                    end_next   = {1'b0, s_block_start} + POS_W'(len_sat);
                    cnt_next   = '0;
                    // transport edge gives start or stop at offset zero
                    if (s_rolling != was_rolling_reg) begin
                        pend_valid_next  = 1'b1;
                        pend_status_next = s_rolling ? ST_START : ST_STOP;
                        pend_offset_next = '0;
                        cnt_next         = CNT_W'(1);
                        was_rolling_next = s_rolling;
                        if (s_rolling) begin
                            ntp_next = {1'b0, s_block_start};
                        end
                    end
                    if (s_tempo_milli_bpm != '0) begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // step is the interval rounded half up; zero step means no ticks
                step_next = q_inc[QUO_W:1];
                if (div_quotient == '0) begin
                    state_next = S_FLUSH;
                end else begin
                    if (lag_sum < (POS_W+1)'(start_reg)) begin
                        ntp_next = {1'b0, start_reg};
                    end
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (!in_blk) begin
                    state_next = S_FLUSH;
                end else if (!(emit && pend_valid_reg && !out_free)) begin
                    ntp_next = ntp_reg + POS_W'(step_reg);
                    if (emit) begin
                        push             = pend_valid_reg;
                        pend_valid_next  = 1'b1;
                        pend_status_next = ST_TICK;
                        pend_offset_next = tick_offset;
                        cnt_next         = cnt_reg + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // the held event is the final one of the block
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_offset_next = m_offset_reg;
        m_last_next   = m_last_reg;
        if (push) begin
            m_valid_next  = 1'b1;
            m_status_next = pend_status_reg;
            m_offset_next = pend_offset_reg;
            m_last_next   = push_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            was_rolling_reg <= 1'b0;
            ntp_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            was_rolling_reg <= was_rolling_next;
            ntp_reg         <= ntp_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg       <= start_next;
        end_reg         <= end_next;
        step_reg        <= step_next;
        cnt_reg         <= cnt_next;
        pend_status_reg <= pend_status_next;
        pend_offset_reg <= pend_offset_next;
        m_status_reg    <= m_status_next;
        m_offset_reg    <= m_offset_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status_byte   = m_status_reg;
    assign m_sample_offset = m_offset_reg;
    assign m_last          = m_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/midi_clock_tick_generator.sv @@
// midi beat clock generator, 24 pulses per quarter note, one audio block per transaction
//
// s_ channel: one transaction per audio block (start sample, length, tempo in
// 1/1000 bpm, rolling flag). m_ channel: the events of that block in order,
// each a status byte (0xF8 tick, 0xFA start, 0xFC stop) with its sample offset;
// m_last marks the final event of a block. A block of zero length, or a zero
// sample rate, gives no events. At most 17 events per block.
// cfg_ channel: writes the sample rate; it is always ready. The user must write
// it only while no block is in flight; the block itself does not enforce it.
// Timing: a block with a nonzero tempo passes through the accept, the
// bit-serial divider (32 quotient bits and a done step), alignment, the tick
// loop over the tick positions (ticks inside the block plus at most a few
// before it) and its exit, then flush; with a zero tempo it goes from accept
// straight to flush. The tick loop takes one step per cycle while the output
// is not stalled, so block time grows as block_length / tick_interval.
// A new block is taken once the previous block's last event sits in the output
// register. With the output full and m_ready low, the tick loop holds its next event.
// Reset: sample rate 48000, transport stopped, next tick position zero.
`default_nettype none

module midi_clock_tick_generator (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [mcg_pkg::RATE_W-1:0]   cfg_sample_rate,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [mcg_pkg::START_W-1:0]  s_block_start,
    input  wire  [mcg_pkg::LEN_W-1:0]    s_block_length,
    input  wire  [mcg_pkg::TEMPO_W-1:0]  s_tempo_milli_bpm,
    input  wire                          s_rolling,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [7:0]                   m_status_byte,
    output logic [mcg_pkg::OFFS_W-1:0]   m_sample_offset,
    output logic                         m_last
);
    import mcg_pkg::*;

    logic [QUO_W-1:0] dividend_reg, dividend_next;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quotient;

    // sample rate register, kept pre-scaled as the divider's dividend
    always_comb begin
        dividend_next = dividend_reg;
        if (cfg_valid && cfg_ready) begin
            dividend_next = QUO_W'(cfg_sample_rate) * QUO_W'(TEMPO_SCALE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dividend_reg <= DIVIDEND_RESET;
        end else begin
            dividend_reg <= dividend_next;
        end
    end

    assign cfg_ready = 1'b1;

    // twice the tick interval
    mcg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (s_tempo_milli_bpm),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // block sequencer and output register
    mcg_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .dividend          (dividend_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_block_start     (s_block_start),
        .s_block_length    (s_block_length),
        .s_tempo_milli_bpm (s_tempo_milli_bpm),
        .s_rolling         (s_rolling),
        .div_start         (div_start),
        .div_done          (div_done),
        .div_quotient      (div_quotient),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status_byte     (m_status_byte),
        .m_sample_offset   (m_sample_offset),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire

@@ rtl/core/mcg_checker.sv @@
// port-level checker for the midi clock tick generator and its bind
`default_nettype none
`include "midi_clock_tick_generator_assert.svh"

module mcg_checker (
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         m_valid,
    input wire                         m_ready,
    input wire [7:0]                   m_status_byte,
    input wire [mcg_pkg::OFFS_W-1:0]   m_sample_offset,
    input wire                         m_last
);
    import mcg_pkg::*;

    // a stalled result transaction holds
    `MCG_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status_byte) && $stable(m_sample_offset) && $stable(m_last), "stalled result changed")

    // only the three realtime codes are emitted
    `MCG_ASSERT_NOW(a_code, aclk, aresetn, m_valid, (m_status_byte == ST_TICK) || (m_status_byte == ST_START) || (m_status_byte == ST_STOP), "illegal status byte")

    // start and stop sit at the block start
    `MCG_ASSERT_NOW(a_edge_off, aclk, aresetn, m_valid && (m_status_byte != ST_TICK), m_sample_offset == '0, "transport event off block start")

    // reset empties the output
    `MCG_ASSERT_NEXT(a_rst, aclk, 1'b1, !aresetn, !m_valid, "result valid after reset")

endmodule

bind midi_clock_tick_generator mcg_checker u_mcg_checker (.*);

`default_nettype wire
